// ===== src/psp_pkg.sv =====
// Package for the push-only script parser: beat payload structs, parse phases,
// status codes and opcode constants. No dependencies.
`default_nettype none

package psp_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
        logic       empty_script;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] push_count;
        logic [13:0] last_push_offset;
        logic [13:0] last_push_length;
        logic        is_witness_program;
        logic [4:0]  witness_version;
    } result_t;

    typedef enum logic [1:0] {
        PHASE_OPCODE = 2'd0,
        PHASE_LENGTH = 2'd1,
        PHASE_DATA   = 2'd2,
        PHASE_HALT   = 2'd3
    } phase_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NONPUSH = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic [7:0] OP_0         = 8'h00;
    localparam logic [7:0] OP_PUSH_MAX  = 8'h4b;
    localparam logic [7:0] OP_PUSHDATA1 = 8'h4c;
    localparam logic [7:0] OP_PUSHDATA2 = 8'h4d;
    localparam logic [7:0] OP_PUSHDATA4 = 8'h4e;
    localparam logic [7:0] OP_1NEGATE   = 8'h4f;
    localparam logic [7:0] OP_1         = 8'h51;
    localparam logic [7:0] OP_16        = 8'h60;
    localparam logic [7:0] OP_VER_BASE  = 8'h50;

    localparam logic [31:0] WP_MIN_LEN = 32'd4;
    localparam logic [31:0] WP_MAX_LEN = 32'd42;

endpackage

`default_nettype wire

// ===== src/push_only_script_last_push_parser_top.sv =====
// Top level of the push-only script parser: byte walker, push bookkeeping and
// result register. Depends on psp_pkg.
//
//   channel  | handshake                  | payload            | beat
//   ---------+----------------------------+--------------------+---------------------
//   item     | item_valid / item_ready    | psp_pkg::item_t    | one script byte
//   result   | result_valid / result_ready| psp_pkg::result_t  | one report per script
//
// One byte beat is taken every cycle; the walker state updates at the accept edge
// and a report, if the beat ends a script, lands in the result register then.
// The result register sets the rate: item_ready drops only while a report is held
// and result_ready is low, and rises again the cycle the report is taken.
// Reset (rst_n low, asynchronous) clears the walker to "expect opcode" with zero
// counters and empties the result register; each report clears the walker the same way.
`default_nettype none

module push_only_script_last_push_parser_top #(
    parameter int MAX_SCRIPT_BYTES = 16384
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire psp_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output psp_pkg::result_t      result
);

    // Position counter must hold MAX_SCRIPT_BYTES itself for the overlong check.
    localparam int POS_W = $clog2(MAX_SCRIPT_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SCRIPT_BYTES);

    // Walker state.
    psp_pkg::phase_t   phase_reg,     phase_next;
    logic [2:0]        len_left_reg,  len_left_next;
    logic [1:0]        len_shift_reg, len_shift_next;
    logic [31:0]       pend_len_reg,  pend_len_next;
    logic [31:0]       data_left_reg, data_left_next;
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [14:0]       pushes_reg,    pushes_next;
    logic [13:0]       last_off_reg,  last_off_next;
    logic [13:0]       last_len_reg,  last_len_next;
    logic [7:0]        byte0_reg,     byte0_next;
    logic [7:0]        byte1_reg,     byte1_next;
    logic [1:0]        err_reg,       err_next;

    // Result register.
    logic              res_valid_reg;
    psp_pkg::result_t  res_reg;
    psp_pkg::result_t  res_next;
    logic              res_fire;

    // Push start, shared by direct, PUSHDATA and small-integer pushes.
    logic              push_begin;
    logic [POS_W-1:0]  push_at;
    logic [31:0]       push_len;

    logic              accept;
    logic [7:0]        b;
    logic [31:0]       len_acc;
    logic [31:0]       data_idx;
    logic [1:0]        status;

    assign b          = item.byte_value;
    assign item_ready = !res_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign len_acc  = pend_len_reg | (32'(b) << {len_shift_reg, 3'b000});
    assign data_idx = pend_len_reg - data_left_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        len_left_next  = len_left_reg;
        len_shift_next = len_shift_reg;
        pend_len_next  = pend_len_reg;
        data_left_next = data_left_reg;
        pos_next       = pos_reg;
        pushes_next    = pushes_reg;
        last_off_next  = last_off_reg;
        last_len_next  = last_len_reg;
        byte0_next     = byte0_reg;
        byte1_next     = byte1_reg;
        err_next       = err_reg;
        push_begin     = 1'b0;
        push_at        = pos_reg;
        push_len       = 32'd0;
        res_fire       = 1'b0;
        res_next       = '0;
        status         = psp_pkg::ST_OK;

        // Walk one byte; a halted walker drops bytes until the script ends.
        if (phase_reg != psp_pkg::PHASE_HALT)
        begin
            if (pos_reg >= MAX_POS)
            begin
                err_next   = psp_pkg::ST_TRUNC;
                phase_next = psp_pkg::PHASE_HALT;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                unique case (phase_reg)
                    psp_pkg::PHASE_OPCODE:
                    begin
                        if (b <= psp_pkg::OP_PUSH_MAX)
                        begin
                            push_begin = 1'b1;
                            push_at    = pos_reg + POS_W'(1);
                            push_len   = 32'(b);
                        end
                        else if (b == psp_pkg::OP_PUSHDATA1 || b == psp_pkg::OP_PUSHDATA2 ||
                                 b == psp_pkg::OP_PUSHDATA4)
                        begin
                            len_left_next  = (b == psp_pkg::OP_PUSHDATA1) ? 3'd1 :
                                             (b == psp_pkg::OP_PUSHDATA2) ? 3'd2 : 3'd4;
                            len_shift_next = 2'd0;
                            pend_len_next  = 32'd0;
                            phase_next     = psp_pkg::PHASE_LENGTH;
                        end
                        else if (b == psp_pkg::OP_1NEGATE ||
                                 (b >= psp_pkg::OP_1 && b <= psp_pkg::OP_16))
                        begin
                            push_begin = 1'b1;
                            push_at    = pos_reg;
                            push_len   = 32'd0;
                        end
                        else
                        begin
                            err_next   = psp_pkg::ST_NONPUSH;
                            phase_next = psp_pkg::PHASE_HALT;
                        end
                    end
                    psp_pkg::PHASE_LENGTH:
                    begin
                        pend_len_next  = len_acc;
                        len_shift_next = len_shift_reg + 2'd1;
                        len_left_next  = len_left_reg - 3'd1;
                        if (len_left_reg == 3'd1)
                        begin
                            push_begin = 1'b1;
                            push_at    = pos_reg + POS_W'(1);
                            push_len   = len_acc;
                        end
                    end
                    psp_pkg::PHASE_DATA:
                    begin
                        if (data_idx == 32'd0)
                        begin
                            byte0_next = b;
                        end
                        else if (data_idx == 32'd1)
                        begin
                            byte1_next = b;
                        end
                        data_left_next = data_left_reg - 32'd1;
                        if (data_left_reg == 32'd1)
                        begin
                            phase_next = psp_pkg::PHASE_OPCODE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (push_begin)
        begin
            pushes_next    = pushes_reg + 15'd1;
            last_off_next  = 14'(push_at);
            pend_len_next  = push_len;
            last_len_next  = push_len[13:0];
            byte0_next     = 8'd0;
            byte1_next     = 8'd0;
            data_left_next = push_len;
            phase_next     = (push_len != 32'd0) ? psp_pkg::PHASE_DATA : psp_pkg::PHASE_OPCODE;
        end

        // End of script: build the report from the post-byte state.
        if (item.empty_script)
        begin
            res_fire        = 1'b1;
            res_next.status = psp_pkg::ST_EMPTY;
        end
        else if (item.last_byte)
        begin
            res_fire = 1'b1;
            status   = err_next;
            if (status == psp_pkg::ST_OK && phase_next != psp_pkg::PHASE_OPCODE)
            begin
                status = psp_pkg::ST_TRUNC;
            end
            if (status == psp_pkg::ST_OK && pushes_next == 15'd0)
            begin
                status = psp_pkg::ST_EMPTY;
            end
            res_next.status = status;
            if (status == psp_pkg::ST_OK)
            begin
                res_next.push_count       = pushes_next;
                res_next.last_push_offset = last_off_next;
                res_next.last_push_length = last_len_next;
                if (pend_len_next >= psp_pkg::WP_MIN_LEN &&
                    pend_len_next <= psp_pkg::WP_MAX_LEN &&
                    (byte0_next == psp_pkg::OP_0 ||
                     (byte0_next >= psp_pkg::OP_1 && byte0_next <= psp_pkg::OP_16)) &&
                    32'(byte1_next) == pend_len_next - 32'd2)
                begin
                    res_next.is_witness_program = 1'b1;
                    res_next.witness_version    = (byte0_next == psp_pkg::OP_0) ? 5'd0 :
                        5'(byte0_next - psp_pkg::OP_VER_BASE);
                end
            end
        end

        // Any report clears the walker for the next script.
        if (res_fire)
        begin
            phase_next     = psp_pkg::PHASE_OPCODE;
            len_left_next  = 3'd0;
            len_shift_next = 2'd0;
            pend_len_next  = 32'd0;
            data_left_next = 32'd0;
            pos_next       = '0;
            pushes_next    = 15'd0;
            last_off_next  = 14'd0;
            last_len_next  = 14'd0;
            byte0_next     = 8'd0;
            byte1_next     = 8'd0;
            err_next       = psp_pkg::ST_OK;
        end
    end

    // Walker state: advance only on an accepted item beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= psp_pkg::PHASE_OPCODE;
            len_left_reg  <= 3'd0;
            len_shift_reg <= 2'd0;
            pend_len_reg  <= 32'd0;
            data_left_reg <= 32'd0;
            pos_reg       <= '0;
            pushes_reg    <= 15'd0;
            last_off_reg  <= 14'd0;
            last_len_reg  <= 14'd0;
            byte0_reg     <= 8'd0;
            byte1_reg     <= 8'd0;
            err_reg       <= psp_pkg::ST_OK;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            len_left_reg  <= len_left_next;
            len_shift_reg <= len_shift_next;
            pend_len_reg  <= pend_len_next;
            data_left_reg <= data_left_next;
            pos_reg       <= pos_next;
            pushes_reg    <= pushes_next;
            last_off_reg  <= last_off_next;
            last_len_reg  <= last_len_next;
            byte0_reg     <= byte0_next;
            byte1_reg     <= byte1_next;
            err_reg       <= err_next;
        end
    end

    // Result register: load a report, hold it until taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept && res_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_fire)
        begin
            res_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != psp_pkg::ST_OK |->
            result.push_count == 15'd0 && result.last_push_offset == 14'd0 &&
            result.last_push_length == 14'd0 && !result.is_witness_program)
        else $error("error report carries nonzero fields");

    a_wp_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.is_witness_program |->
            result.status == psp_pkg::ST_OK && result.last_push_length >= 14'd4 &&
            result.last_push_length <= 14'd42 && result.witness_version <= 5'd16)
        else $error("witness program flag on a malformed push");

    a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.empty_script |=>
            result_valid && result.status == psp_pkg::ST_EMPTY)
        else $error("empty script beat gave no empty report");

    a_clear_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.last_byte || item.empty_script) |=>
            phase_reg == psp_pkg::PHASE_OPCODE && pos_reg == '0 && pushes_reg == 15'd0)
        else $error("walker not cleared after a report");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("position ran past the script limit");
`endif

endmodule

`default_nettype wire
